// File: hdl/rational_arithmetic_unit_defines.svh
// assertion macros for the rational arithmetic unit
// used by the top level only, no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rau_pkg.sv
// types, codes and helpers of the rational arithmetic unit
// no dependencies
package rau_pkg;

    localparam int MAG_W = 64;
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        CMD_NORM, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP, CMD_RECIP, CMD_REM
    } t_cmd;

    typedef enum logic [1:0] {ST_OK, ST_ZERO_DEN, ST_DIV_ZERO, ST_OVERFLOW} t_status;
    typedef enum logic [1:0] {ORD_LT, ORD_EQ, ORD_GT} t_order;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_CMP, S_REM, S_FIN, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_out_item;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

// File: hdl/rau_in_if.sv
// input channel of the rational arithmetic unit
// depends on rau_pkg
interface rau_in_if;
    import rau_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rau_out_if.sv
// output channel of the rational arithmetic unit
// depends on rau_pkg
interface rau_out_if;
    import rau_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rau_gcd.sv
// binary gcd of two nonzero 64-bit magnitudes, one step a cycle
// depends on rau_pkg
module rau_gcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::MAG_W-1:0]  i_a,
    input  logic [rau_pkg::MAG_W-1:0]  i_b,
    output logic                       o_done,
    output logic [rau_pkg::MAG_W-1:0]  o_gcd
);
    import rau_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [MAG_W-1:0] r_u;
    logic [MAG_W-1:0] r_v;
    logic [MAG_W-1:0] r_g;
    logic [5:0]       r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_u == r_v);
            if (i_start) begin
                r_u    <= i_a;
                r_v    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_u == r_v) begin
                    r_g    <= r_u << r_k;
                    r_busy <= 1'b0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 6'd1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;
endmodule

// File: hdl/rau_divider.sv
// restoring divider for 64-bit magnitudes, one quotient bit a cycle
// depends on rau_pkg
module rau_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::MAG_W-1:0]  i_dividend,
    input  logic [rau_pkg::MAG_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rau_pkg::MAG_W-1:0]  o_quotient,
    output logic [rau_pkg::MAG_W-1:0]  o_remainder
);
    import rau_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [MAG_W-1:0] r_quo;
    logic [MAG_W-1:0] r_rem;
    logic [MAG_W-1:0] r_div;
    logic [MAG_W:0]   w_sh;
    logic [MAG_W:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[MAG_W-1]};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_quo <= i_dividend;
                r_div <= i_divisor;
                r_rem <= '0;
                r_cnt <= CNT_W'(MAG_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (!w_diff[MAG_W]) begin
                    r_rem <= w_diff[MAG_W-1:0];
                    r_quo <= {r_quo[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[MAG_W-1:0];
                    r_quo <= {r_quo[MAG_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// File: hdl/rational_arithmetic_unit.sv
// channel   dir  payload
// i_in      in   command, a_num, a_den, b_num, b_den
// o_out     out  res_num, res_den, order, status
//
// one item at a time: errors skip all arithmetic, compare skips the gcd, and a zero
// result skips the gcd and divisions; others run the binary gcd loop and two divisions
// on the shared restoring divider (remainder uses it a third time)
// synchronous active-low reset clears the sequencer and output valid
// a finished result waits in the output register; the next item is taken
// meanwhile, but its result waits until that register is free
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
    parameter int WORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WORD_WIDTH - 1);

    t_state           r_state, n_state;
    logic [2:0]       r_cmd;
    logic [31:0]      r_an, r_ad, r_bn, r_bd;
    logic             r_as, r_bs, r_neg;
    logic [MAG_W-1:0] r_x, r_y, r_nm, r_dm;
    logic [1:0]       r_mcnt;
    t_out_item        r_res, r_out;
    logic             r_ovalid;
    logic             r_dstart, r_gstart;
    logic [MAG_W-1:0] r_dva, r_dvb;

    logic             w_acc;
    logic [31:0]      w_an, w_ad, w_bn, w_bd;
    logic             w_uses_b;
    t_status          w_est;
    logic [31:0]      w_ma, w_mb;
    logic [MAG_W-1:0] w_prod;
    logic             w_ys, w_xn, w_yn, w_ovf;
    logic             w_ddone, w_gdone;
    logic [MAG_W-1:0] w_quo, w_rem, w_gcd;
    logic             w_free;

    rau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_dividend(r_dva), .i_divisor(r_dvb),
        .o_done(w_ddone), .o_quotient(w_quo), .o_remainder(w_rem)
    );

    rau_gcd u_gcd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_gstart),
        .i_a(r_nm), .i_b(r_dm), .o_done(w_gdone), .o_gcd(w_gcd)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
    assign w_free      = !r_ovalid || o_out.ready;

    assign w_an = mag32(i_in.data.a_num);
    assign w_ad = mag32(i_in.data.a_den);
    assign w_bn = mag32(i_in.data.b_num);
    assign w_bd = mag32(i_in.data.b_den);
    assign w_uses_b = (i_in.data.command >= CMD_ADD) && (i_in.data.command <= CMD_CMP);

    always_comb begin
        w_est = ST_OK;
        if (i_in.data.command == CMD_REM) begin
            if (w_bn == '0) w_est = ST_DIV_ZERO;
        end else if (w_ad == '0 || (w_uses_b && w_bd == '0)) begin
            w_est = ST_ZERO_DEN;
        end else if ((i_in.data.command == CMD_DIV && w_bn == '0)
                     || (i_in.data.command == CMD_RECIP && w_an == '0)) begin
            w_est = ST_DIV_ZERO;
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = r_ad;
        w_mb = r_bd;
        case (r_mcnt)
            2'd0: begin
                w_ma = r_an;
                w_mb = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            2'd1: begin
                if (r_cmd == CMD_MUL) begin
                    w_ma = r_ad;
                    w_mb = r_bd;
                end else begin
                    w_ma = r_ad;
                    w_mb = r_bn;
                end
            end
            default: begin
                w_ma = r_ad;
                w_mb = r_bd;
            end
        endcase
    end
    assign w_prod = MAG_W'(w_ma) * MAG_W'(w_mb);

    assign w_ys  = (r_cmd == CMD_SUB) ? !r_bs : r_bs;
    assign w_xn  = r_as && (r_x != '0);
    assign w_yn  = r_bs && (r_y != '0);
    assign w_ovf = (r_dm > LIM - 1'b1) || (r_nm > (r_neg ? LIM : LIM - 1'b1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_est != ST_OK) n_state = S_DONE;
                    else if (i_in.data.command == CMD_REM) n_state = S_REM;
                    else if (w_uses_b) n_state = S_MUL;
                    else n_state = S_FIN;
                end
            end
            S_MUL: begin
                if (r_mcnt == 2'd1 && r_cmd == CMD_CMP) n_state = S_CMP;
                else if (r_mcnt == 2'd1 && (r_cmd == CMD_MUL || r_cmd == CMD_DIV))
                    n_state = S_FIN;
                else if (r_mcnt == 2'd2) n_state = S_SUM;
            end
            S_SUM:   n_state = S_FIN;
            S_CMP:   n_state = S_DONE;
            S_REM:   if (w_ddone) n_state = S_FIN;
            S_FIN:   n_state = (r_nm == '0) ? S_DONE : S_GCD;
            S_GCD:   if (w_gdone) n_state = S_DIVN;
            S_DIVN:  if (w_ddone) n_state = S_DIVD;
            S_DIVD:  if (w_ddone) n_state = S_CHECK;
            S_CHECK: n_state = S_DONE;
            S_DONE:  if (w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_gstart <= 1'b0;
            r_mcnt   <= '0;
        end else begin
            r_dstart <= (w_acc && i_in.data.command == CMD_REM && w_est == ST_OK)
                        || (r_state == S_GCD && w_gdone)
                        || (r_state == S_DIVN && w_ddone);
            r_gstart <= (r_state == S_FIN) && (r_nm != '0);
            if (r_state == S_DONE && w_free) r_ovalid <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cmd  <= i_in.data.command;
                        r_an   <= w_an;
                        r_ad   <= w_ad;
                        r_bn   <= w_bn;
                        r_bd   <= w_bd;
                        r_as   <= i_in.data.a_num[31] ^ i_in.data.a_den[31];
                        r_bs   <= i_in.data.b_num[31] ^ i_in.data.b_den[31];
                        r_mcnt <= '0;
                        r_res  <= '{res_num: '0, res_den: 31'd1, order: ORD_LT,
                                    status: w_est};
                        r_nm   <= (i_in.data.command == CMD_RECIP) ? MAG_W'(w_ad)
                                                                   : MAG_W'(w_an);
                        r_dm   <= (i_in.data.command == CMD_RECIP) ? MAG_W'(w_an)
                                                                   : MAG_W'(w_ad);
                        r_neg  <= (i_in.data.command == CMD_REM) ? i_in.data.a_num[31]
                                  : (i_in.data.a_num[31] ^ i_in.data.a_den[31]);
                        if (i_in.data.command == CMD_REM) begin
                            r_dva <= MAG_W'(w_an);
                            r_dvb <= MAG_W'(w_bn);
                        end
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    case (r_mcnt)
                        2'd0: r_x <= w_prod;
                        2'd1: begin
                            r_y   <= w_prod;
                            r_nm  <= r_x;
                            r_dm  <= w_prod;
                            r_neg <= r_as ^ r_bs;
                        end
                        default: r_dm <= w_prod;
                    endcase
                end
                S_SUM: begin
                    if (r_as == w_ys) begin
                        r_nm  <= r_x + r_y;
                        r_neg <= r_as;
                    end else if (r_x >= r_y) begin
                        r_nm  <= r_x - r_y;
                        r_neg <= r_as;
                    end else begin
                        r_nm  <= r_y - r_x;
                        r_neg <= w_ys;
                    end
                end
                S_CMP: begin
                    if (w_xn != w_yn) r_res.order <= w_xn ? ORD_LT : ORD_GT;
                    else if (r_x == r_y) r_res.order <= ORD_EQ;
                    else if (w_xn) r_res.order <= (r_x > r_y) ? ORD_LT : ORD_GT;
                    else r_res.order <= (r_x < r_y) ? ORD_LT : ORD_GT;
                end
                S_REM: begin
                    if (w_ddone) begin
                        r_nm <= w_rem;
                        r_dm <= MAG_W'(1);
                    end
                end
                S_GCD: begin
                    if (w_gdone) begin
                        r_dva <= r_nm;
                        r_dvb <= w_gcd;
                    end
                end
                S_DIVN: begin
                    if (w_ddone) begin
                        r_nm  <= w_quo;
                        r_dva <= r_dm;
                    end
                end
                S_DIVD: begin
                    if (w_ddone) r_dm <= w_quo;
                end
                S_CHECK: begin
                    if (w_ovf) begin
                        r_res.status <= ST_OVERFLOW;
                    end else begin
                        r_res.res_num <= r_neg ? (32'd0 - r_nm[31:0]) : r_nm[31:0];
                        r_res.res_den <= r_dm[30:0];
                    end
                end
                S_DONE: begin
                    if (w_free) r_out <= r_res;
                end
                default: ;
            endcase
        end
    end

    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out.valid && o_out.data.status != ST_OK, o_out.data.res_num == 0 && o_out.data.res_den == 31'd1, "error result not 0/1")
    `RAU_ASSERT_IMP(a_order_cmp, i_clk, i_rst_n, o_out.valid && o_out.data.order != ORD_LT, o_out.data.status == ST_OK && o_out.data.res_num == 0, "order set outside compare")
    `RAU_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "item taken while busy")
endmodule

// File: test/rational_arithmetic_unit_tb.sv
// self-checking testbench of the rational arithmetic unit
// depends on rau_pkg, rau_in_if, rau_out_if and the top level
// directed cases, then random fractions, checked against an exact predictor
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int WW = 32;
    localparam longint unsigned LIM = 64'd1 << (WW - 1);
    localparam int CYCLE_LIMIT = 1_500_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit #(.WORD_WIDTH(WW)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_out_item expected_q[$];
    int  n_errors = 0;
    longint cycles = 0;
    bit  no_idle = 1'b0;
    int  hold_off = 0;

    typedef struct {
        bit neg;
        longint unsigned mag;
    } t_smag;

    function automatic t_smag to_smag(logic [31:0] v);
        t_smag r;
        r.neg = v[31];
        r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        return r;
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_out_item make_result(bit neg, longint unsigned nm,
            longint unsigned dm, t_order ord, t_status st);
        t_out_item r;
        longint unsigned n;
        n = neg ? (64'd0 - nm) : nm;
        r.res_num = n[31:0];
        r.res_den = dm[30:0];
        r.order   = ord;
        r.status  = st;
        return r;
    endfunction

    function automatic t_out_item reduce(bit neg, longint unsigned nm, longint unsigned dm);
        longint unsigned g;
        if (nm == 0) return make_result(0, 0, 1, ORD_LT, ST_OK);
        g = gcd_of(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (dm > LIM - 1 || nm > (neg ? LIM : LIM - 1))
            return make_result(0, 0, 1, ORD_LT, ST_OVERFLOW);
        return make_result(neg, nm, dm, ORD_LT, ST_OK);
    endfunction

    function automatic t_out_item predict_fraction(t_in_item it);
        t_smag an, ad, bn, bd, x, y, s;
        bit uses_b;
        t_cmd c;
        t_order o;
        c = t_cmd'(it.command);
        an = to_smag(it.a_num);
        ad = to_smag(it.a_den);
        bn = to_smag(it.b_num);
        bd = to_smag(it.b_den);
        uses_b = (c inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP});
        if (c == CMD_REM) begin
            if (bn.mag == 0) return make_result(0, 0, 1, ORD_LT, ST_DIV_ZERO);
            return reduce(an.neg, an.mag % bn.mag, 1);
        end
        if (ad.mag == 0 || (uses_b && bd.mag == 0))
            return make_result(0, 0, 1, ORD_LT, ST_ZERO_DEN);
        an.neg = an.neg ^ ad.neg;
        bn.neg = bn.neg ^ bd.neg;
        case (c)
            CMD_NORM: return reduce(an.neg, an.mag, ad.mag);
            CMD_ADD, CMD_SUB: begin
                x.neg = an.neg;
                x.mag = an.mag * bd.mag;
                y.neg = (c == CMD_SUB) ? !bn.neg : bn.neg;
                y.mag = bn.mag * ad.mag;
                if (x.neg == y.neg) begin
                    s.neg = x.neg;
                    s.mag = x.mag + y.mag;
                end else if (x.mag >= y.mag) begin
                    s.neg = x.neg;
                    s.mag = x.mag - y.mag;
                end else begin
                    s.neg = y.neg;
                    s.mag = y.mag - x.mag;
                end
                return reduce(s.neg, s.mag, ad.mag * bd.mag);
            end
            CMD_MUL: return reduce(an.neg ^ bn.neg, an.mag * bn.mag, ad.mag * bd.mag);
            CMD_DIV: begin
                if (bn.mag == 0) return make_result(0, 0, 1, ORD_LT, ST_DIV_ZERO);
                return reduce(an.neg ^ bn.neg, an.mag * bd.mag, ad.mag * bn.mag);
            end
            CMD_CMP: begin
                x.mag = an.mag * bd.mag;
                y.mag = bn.mag * ad.mag;
                x.neg = an.neg && x.mag != 0;
                y.neg = bn.neg && y.mag != 0;
                if (x.neg != y.neg) o = x.neg ? ORD_LT : ORD_GT;
                else if (x.mag == y.mag) o = ORD_EQ;
                else if (x.neg) o = (x.mag > y.mag) ? ORD_LT : ORD_GT;
                else o = (x.mag < y.mag) ? ORD_LT : ORD_GT;
                return make_result(0, 0, 1, o, ST_OK);
            end
            default: begin
                if (an.mag == 0) return make_result(0, 0, 1, ORD_LT, ST_DIV_ZERO);
                return reduce(an.neg, ad.mag, an.mag);
            end
        endcase
    endfunction

    // one transfer on the input channel, with random idle cycles before it unless no_idle is set
    task automatic send_item(t_in_item it);
        while (!no_idle && $urandom_range(99) < 17) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_q.push_back(predict_fraction(it));
    endtask

    task automatic send_op(t_cmd c, int an, int ad, int bn, int bd);
        t_in_item it;
        it.command = c;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(40)) - 20);
            2: return {1'($urandom_range(1)), 31'h7fff_ffff} ^ 32'($urandom_range(3));
            3: return 32'($signed($urandom_range(2000)) - 1000) * 32'($urandom_range(60));
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    task automatic test_directed();
        t_cmd c;
        for (int k = 0; k < 8; k++) begin
            c = t_cmd'(k);
            send_op(c, 6, -4, -3, 9);
        end
        send_op(CMD_NORM, 5, 0, 1, 1);
        send_op(CMD_ADD, 1, 2, 1, 0);
        send_op(CMD_DIV, 1, 2, 0, 3);
        send_op(CMD_RECIP, 0, 7, 1, 1);
        send_op(CMD_REM, 7, 0, 0, 0);
        send_op(CMD_REM, 32'h8000_0000, 0, -1, 0);
        send_op(CMD_NORM, 32'h8000_0000, -1, 0, 0);
        send_op(CMD_NORM, 32'h8000_0000, 1, 0, 0);
        send_op(CMD_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_op(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000);
        send_op(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_op(CMD_CMP, 1, 3, 2, 6);
        send_op(CMD_CMP, -1, 3, 0, -5);
        send_op(CMD_RECIP, -3, 32'h8000_0000, 0, 0);
        send_op(CMD_SUB, 3, 4, 3, 4);
        send_op(CMD_DIV, -1, -1, 32'hffff_ffff, 32'h8000_0000);
    endtask

    task automatic test_random(int count);
        t_in_item it;
        for (int k = 0; k < count; k++) begin
            it.command = 3'($urandom_range(7));
            it.a_num = rand_word();
            it.a_den = rand_word();
            it.b_num = rand_word();
            it.b_den = rand_word();
            send_item(it);
        end
    endtask

    // receiver stalls for a long stretch while the sender keeps offering items
    task automatic test_backpressure();
        hold_off = 3000;
        test_random(6);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random(60);
        no_idle = 1'b0;
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off = hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= 17);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, out_ch.data);
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (out_ch.data !== exp_r) begin
                    $display("%0t: expected num %0d den %0d ord %0d st %0d, got %0d %0d %0d %0d",
                        $time, exp_r.res_num, exp_r.res_den, exp_r.order, exp_r.status,
                        out_ch.data.res_num, out_ch.data.res_den, out_ch.data.order,
                        out_ch.data.status);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_back_to_back();
        test_random(420);
        wait_drained();
        repeat (500) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: rational_arithmetic_unit.f
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_in_if.sv
hdl/rau_out_if.sv
hdl/rau_gcd.sv
hdl/rau_divider.sv
hdl/rational_arithmetic_unit.sv
test/rational_arithmetic_unit_tb.sv
